>>> rtl/sapm_pkg.sv
// Shared types and constants of the six-axis PID thruster mixer.
`timescale 1ns / 1ps
package sapm_pkg;

    // angle and integral limits, Q10
    localparam logic signed [17:0] PI_Q10     = 18'sd3217;
    localparam logic signed [17:0] TWO_PI_Q10 = 18'sd6434;
    localparam logic signed [18:0] SUM_LIMIT  = 19'sd2611;

    // degrees to radians, Q16
    localparam logic signed [15:0] DEG_TO_RAD = 16'sd18301;

    // fixed surge gains, Q10
    localparam logic signed [10:0] SURGE_KP = 11'sd657;
    localparam logic signed [10:0] SURGE_KD = 11'sd774;
    localparam logic signed [10:0] SURGE_KI = 11'sd7;

    // heave damping
    localparam logic signed [23:0] HEAVE_LIMIT = 24'sd512;
    localparam logic signed [35:0] HEAVE_DAMP  = 36'sd998;

    // PWM mapping
    localparam logic [10:0] PWM_MAX     = 11'd1750;
    localparam logic [10:0] PWM_MIN     = 11'd1250;
    localparam logic [10:0] PWM_NEUTRAL = 11'd1500;
    localparam logic [10:0] PWM_POS_BASE = 11'd1530;
    localparam logic [10:0] PWM_NEG_BASE = 11'd1470;
    localparam logic signed [26:0] POS_SAT_FORCE = 27'sd1437;
    localparam logic signed [26:0] NEG_SAT_FORCE = 27'sd1122;
    localparam logic [21:0] NEG_SCALE = 22'd200;
    // floor(f * 9250 / 60416) equals (f * POS_RECIP) >> POS_RECIP_SHIFT for f below 16384
    localparam logic [34:0] POS_RECIP       = 35'd10274712;
    localparam int          POS_RECIP_SHIFT = 26;

    // register indexes
    localparam logic [1:0] CFG_PROP  = 2'd0;
    localparam logic [1:0] CFG_INTEG = 2'd1;
    localparam logic [1:0] CFG_DERIV = 2'd2;
    localparam logic [1:0] CFG_DEAD  = 2'd3;
    localparam logic [9:0] DEAD_RESET = 10'd102;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ERR,
        OP_WRAP,
        OP_UPD,
        OP_MAC_P,
        OP_MAC_D,
        OP_MAC_I,
        OP_OUT,
        OP_HEAVE_MUL,
        OP_HEAVE_SUB,
        OP_SWAY_MUL,
        OP_FORCE,
        OP_PWM_INIT,
        OP_PWM_DONE
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [2:0] ax;
    } t_cmd;

    typedef struct packed {
        logic wrap_ok;
        logic out_full;
    } t_stat;

endpackage

>>> rtl/sapm_dp.sv
// Datapath: error forming, shared PID multiply-accumulate, mixing and PWM lanes.
`timescale 1ns / 1ps
module sapm_dp import sapm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_idx,
    input  logic [59:0]        i_cfg_data,
    input  logic signed [15:0] i_deg [3],
    input  logic signed [15:0] i_depth,
    input  logic signed [15:0] i_tgt [6],
    input  logic               i_stall,
    output logic               o_valid,
    output logic [10:0]        o_thrust [6]
);

    // configuration
    logic [59:0] r_kp, r_ki, r_kd;
    logic [9:0]  r_dead;

    // controller history
    logic signed [17:0] r_last_err [6];
    logic signed [12:0] r_sum [6];
    logic signed [15:0] r_last_tgt [6];
    logic signed [23:0] r_hist;
    logic               r_valid;

    // working registers
    logic signed [15:0] r_deg [3];
    logic signed [15:0] r_depth;
    logic signed [15:0] r_tgt [6];
    logic signed [17:0] r_e;
    logic signed [18:0] r_de;
    logic signed [12:0] r_s;
    logic signed [31:0] r_acc;
    logic signed [23:0] r_u [6];
    logic signed [35:0] r_hprod;
    logic               r_hbig;
    logic signed [39:0] r_sprod;
    logic signed [26:0] r_f [6];
    logic [7:0]         r_q [6];
    logic               r_dv [6];
    logic [10:0]        r_pwm [6];
    logic [10:0]        r_thrust [6];

    logic [2:0] w_ax;
    assign w_ax = i_cmd.ax;

    function automatic logic signed [10:0] gain_field(input logic [59:0] g_word,
                                                       input logic [2:0] ax);
        logic [9:0] f;
        f = g_word[10*ax +: 10];
        return {f[9], f};
    endfunction

    function automatic logic [14:0] sway_alpha(input logic signed [15:0] t1);
        logic [16:0] mag;
        logic [6:0]  key;
        logic        neg;
        logic [14:0] a;
        neg = t1[15];
        mag = neg ? (17'd0 - {t1[15], t1}) : {1'b0, t1};
        key = mag[16:10];
        a = 15'd0;
        case (key)
            7'd2:    a = 15'd102;
            7'd3:    a = neg ? 15'd102 : 15'd1126;
            7'd5:    a = neg ? 15'd307 : 15'd10752;
            7'd10:   a = neg ? 15'd10752 : 15'd1331;
            default: a = 15'd0;
        endcase
        return a;
    endfunction

    // raw error of the current axis
    logic signed [15:0] w_deg, w_tgt, w_rad;
    logic signed [31:0] w_rad_prod, w_rad_sum;
    logic signed [17:0] w_e_new;
    always_comb begin
        case (w_ax)
            3'd0:    w_deg = r_deg[0];
            3'd1:    w_deg = r_deg[1];
            default: w_deg = r_deg[2];
        endcase
        w_tgt      = r_tgt[w_ax];
        w_rad_prod = w_deg * DEG_TO_RAD;
        w_rad_sum  = w_rad_prod + 32'sd32768;
        w_rad      = w_rad_sum[31:16];
        case (w_ax)
            3'd0, 3'd1, 3'd2: w_e_new = 18'(w_tgt) - 18'(w_rad);
            3'd5:             w_e_new = 18'(w_tgt) - 18'(r_depth);
            default:          w_e_new = 18'(w_tgt);
        endcase
    end

    // derivative and clamped sum, the sum cleared when the setpoint changes
    logic signed [18:0] w_de, w_s_raw;
    logic signed [12:0] w_s;
    always_comb begin
        w_de    = 19'(r_e) - 19'(r_last_err[w_ax]);
        w_s_raw = 19'(r_sum[w_ax]) + 19'(r_e);
        if (w_s_raw > SUM_LIMIT) begin
            w_s = 13'(SUM_LIMIT);
        end else if (w_s_raw < -SUM_LIMIT) begin
            w_s = 13'(-SUM_LIMIT);
        end else begin
            w_s = w_s_raw[12:0];
        end
        if (r_last_tgt[w_ax] != w_tgt) begin
            w_s = 13'sd0;
        end
    end

    // shared gain multiply
    logic               w_fixed;
    logic signed [10:0] w_g;
    logic signed [18:0] w_x;
    logic signed [29:0] w_mac;
    logic signed [31:0] w_u_full;
    always_comb begin
        w_fixed = (w_ax == 3'd0) && (r_tgt[0] == 16'sd0);
        case (i_cmd.op)
            OP_MAC_P: begin
                w_g = w_fixed ? SURGE_KP : gain_field(r_kp, w_ax);
                w_x = 19'(r_e);
            end
            OP_MAC_D: begin
                w_g = w_fixed ? SURGE_KD : gain_field(r_kd, w_ax);
                w_x = r_de;
            end
            default: begin
                w_g = w_fixed ? SURGE_KI : gain_field(r_ki, w_ax);
                w_x = 19'(r_s);
            end
        endcase
        w_mac = 30'(w_g) * 30'(w_x);
        if (w_fixed) begin
            w_u_full = (r_acc + 32'sd512) >>> 10;
        end else begin
            w_u_full = (r_acc + 32'sd32) >>> 6;
        end
    end

    // heave damping, sway term and mixing
    logic signed [24:0] w_hdiff;
    logic signed [35:0] w_hadj;
    logic signed [23:0] w_u2;
    logic signed [39:0] w_aw_full;
    logic signed [26:0] w_aw, w_s0, w_w1, w_h2, w_r3, w_p4, w_y5;
    always_comb begin
        w_hdiff   = 25'(r_u[2]) - 25'(r_hist);
        w_hadj    = (r_hprod + 36'sd512) >>> 10;
        w_u2      = r_hbig ? (r_u[2] - w_hadj[23:0]) : r_u[2];
        w_aw_full = (r_sprod + 40'sd512) >>> 10;
        w_aw      = w_aw_full[26:0];
        w_s0      = 27'(r_u[0]);
        w_w1      = 27'(r_u[1]);
        w_h2      = 27'(r_u[2]);
        w_r3      = 27'(r_u[3]);
        w_p4      = 27'(r_u[4]);
        w_y5      = 27'(r_u[5]);
    end

    // PWM lanes
    logic signed [26:0] w_dead;
    logic signed [26:0] w_nf [6];
    logic [34:0]        w_px [6];
    logic [21:0]        w_nx [6];
    logic [10:0]        n_pwm [6];
    logic               n_dv [6];
    logic [7:0]         n_q [6];
    always_comb begin
        w_dead = $signed({17'd0, r_dead});
        for (int i = 0; i < 6; i++) begin
            w_nf[i] = -r_f[i];
            // scale a positive force by 9250/60416 through a reciprocal multiply
            w_px[i] = 35'(r_f[i][10:0]) * POS_RECIP;
            n_q[i]  = w_px[i][POS_RECIP_SHIFT +: 8];
            w_nx[i] = (22'(w_nf[i][10:0]) * NEG_SCALE + 22'd1023) >> 10;
            n_dv[i] = 1'b0;
            if (r_f[i] >= w_dead) begin
                if (r_f[i] >= POS_SAT_FORCE) begin
                    n_pwm[i] = PWM_MAX;
                end else begin
                    n_pwm[i] = PWM_POS_BASE;
                    n_dv[i]  = 1'b1;
                end
            end else if (r_f[i] <= -w_dead) begin
                if (w_nf[i] >= NEG_SAT_FORCE) begin
                    n_pwm[i] = PWM_MIN;
                end else begin
                    n_pwm[i] = PWM_NEG_BASE - w_nx[i][10:0];
                end
            end else begin
                n_pwm[i] = PWM_NEUTRAL;
            end
        end
    end

    // configuration, history and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp    <= '0;
            r_ki    <= '0;
            r_kd    <= '0;
            r_dead  <= DEAD_RESET;
            r_hist  <= '0;
            r_valid <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                r_last_err[i] <= '0;
                r_sum[i]      <= '0;
                r_last_tgt[i] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_PROP:  r_kp   <= i_cfg_data;
                    CFG_INTEG: r_ki   <= i_cfg_data;
                    CFG_DERIV: r_kd   <= i_cfg_data;
                    CFG_DEAD:  r_dead <= i_cfg_data[9:0];
                    default:   r_dead <= r_dead;
                endcase
            end
            if (i_cmd.op == OP_UPD) begin
                r_last_err[w_ax] <= r_e;
                r_sum[w_ax]      <= w_s;
                r_last_tgt[w_ax] <= w_tgt;
            end
            if (i_cmd.op == OP_HEAVE_SUB) begin
                r_hist <= w_u2;
            end
            // drop the beat once taken, set it when a new one is ready
            if (i_cmd.op == OP_PWM_DONE) begin
                r_valid <= 1'b1;
            end else if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // working datapath
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_deg   <= i_deg;
                r_depth <= i_depth;
                r_tgt   <= i_tgt;
            end
            OP_ERR: r_e <= w_e_new;
            OP_WRAP: begin
                if (r_e > PI_Q10) begin
                    r_e <= r_e - TWO_PI_Q10;
                end else if (r_e <= -PI_Q10) begin
                    r_e <= r_e + TWO_PI_Q10;
                end
            end
            OP_UPD: begin
                r_de  <= w_de;
                r_s   <= w_s;
                r_acc <= '0;
            end
            OP_MAC_P, OP_MAC_D, OP_MAC_I: r_acc <= r_acc + 32'(w_mac);
            OP_OUT: r_u[w_ax] <= w_u_full[23:0];
            OP_HEAVE_MUL: begin
                r_hprod <= 36'(w_hdiff) * HEAVE_DAMP;
                r_hbig  <= r_u[2] > HEAVE_LIMIT;
            end
            OP_HEAVE_SUB: r_u[2] <= w_u2;
            OP_SWAY_MUL: r_sprod <= $signed({25'd0, sway_alpha(r_tgt[1])}) * 40'(r_u[1]);
            OP_FORCE: begin
                r_f[0] <= w_h2 - w_p4 - w_r3;
                r_f[1] <= w_h2 - w_p4 + w_r3;
                r_f[2] <= (w_h2 <<< 1) + (w_p4 <<< 1);
                r_f[3] <= w_y5 + w_s0 + w_aw;
                r_f[4] <= w_s0 - w_y5 - w_aw;
                r_f[5] <= w_w1;
            end
            OP_PWM_INIT: begin
                for (int i = 0; i < 6; i++) begin
                    r_pwm[i] <= n_pwm[i];
                    r_dv[i]  <= n_dv[i];
                    r_q[i]   <= n_q[i];
                end
            end
            OP_PWM_DONE: begin
                for (int i = 0; i < 6; i++) begin
                    r_thrust[i] <= r_dv[i] ? (r_pwm[i] + 11'(r_q[i])) : r_pwm[i];
                end
            end
            default: r_e <= r_e;
        endcase
    end

    assign o_stat.wrap_ok  = (r_e <= PI_Q10) && (r_e > -PI_Q10);
    assign o_stat.out_full = r_valid && i_stall;
    assign o_valid  = r_valid;
    assign o_thrust = r_thrust;

endmodule

>>> rtl/sapm_ctrl.sv
// Sequencer: steps the datapath through six axes, heave, mixing and PWM.
`timescale 1ns / 1ps
module sapm_ctrl import sapm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_ERR, S_WRAP, S_UPD, S_MP, S_MD, S_MI, S_OUT,
        S_HMUL, S_HSUB, S_SMUL, S_FORCE, S_PINIT, S_PDONE
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_ax, n_ax;
    t_op        w_op;

    // next state and command
    always_comb begin
        n_state = r_state;
        n_ax    = r_ax;
        w_op    = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    w_op    = OP_LOAD;
                    n_ax    = 3'd0;
                    n_state = S_ERR;
                end
            end
            S_ERR: begin
                w_op    = OP_ERR;
                n_state = (r_ax < 3'd3) ? S_WRAP : S_UPD;
            end
            S_WRAP: begin
                if (i_stat.wrap_ok) begin
                    n_state = S_UPD;
                end else begin
                    w_op = OP_WRAP;
                end
            end
            S_UPD: begin
                w_op    = OP_UPD;
                n_state = S_MP;
            end
            S_MP: begin
                w_op    = OP_MAC_P;
                n_state = S_MD;
            end
            S_MD: begin
                w_op    = OP_MAC_D;
                n_state = S_MI;
            end
            S_MI: begin
                w_op    = OP_MAC_I;
                n_state = S_OUT;
            end
            S_OUT: begin
                w_op = OP_OUT;
                if (r_ax == 3'd5) begin
                    n_state = S_HMUL;
                end else begin
                    n_ax    = r_ax + 3'd1;
                    n_state = S_ERR;
                end
            end
            S_HMUL: begin
                w_op    = OP_HEAVE_MUL;
                n_state = S_HSUB;
            end
            S_HSUB: begin
                w_op    = OP_HEAVE_SUB;
                n_state = S_SMUL;
            end
            S_SMUL: begin
                w_op    = OP_SWAY_MUL;
                n_state = S_FORCE;
            end
            S_FORCE: begin
                w_op    = OP_FORCE;
                n_state = S_PINIT;
            end
            S_PINIT: begin
                w_op    = OP_PWM_INIT;
                n_state = S_PDONE;
            end
            S_PDONE: begin
                // hold until the output register is free
                if (!i_stat.out_full) begin
                    w_op    = OP_PWM_DONE;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ax    <= 3'd0;
        end else begin
            r_state <= n_state;
            r_ax    <= n_ax;
        end
    end

    assign o_stall  = (r_state != S_IDLE);
    assign o_cmd.op = w_op;
    assign o_cmd.ax = r_ax;

    // an accepted beat starts on axis 0
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid) |=> (r_state == S_ERR && r_ax == 3'd0))
        else $error("accepted beat did not start on axis 0");

    // the axis index stays within six axes
    a_ax_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ax <= 3'd5)
        else $error("axis index out of range");

    // a full output register holds the sequencer in its final state
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PDONE && i_stat.out_full) |=> (r_state == S_PDONE))
        else $error("result overwrote a pending beat");

    // wrap steps only on the angle axes
    a_wrap_ax: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRAP) |-> (r_ax < 3'd3))
        else $error("wrap on a linear axis");

endmodule

>>> rtl/six_axis_pid_thruster_mixer_top.sv
// Top level of the six-axis PID controller with thruster mixing.
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_stall    angles, depth, six setpoints
//  output    out        o_valid / i_stall    six PWM commands
//  config    in         i_cfg_wr_en          i_cfg_idx, i_cfg_data
//
// The next beat can be taken in the same cycle that the result of the last one
// turns valid. Each axis steps through an error, an update, three multiply-
// accumulate and an output step; each angle axis adds a wrap check and up to
// seven wrap steps. Heave, sway, mixing, PWM scaling and the write add six steps.
// Reset is synchronous and clears gains, deadband (to 102) and all history.
// A stalled output holds the sequencer at its last step and the input stalled.
`timescale 1ns / 1ps
module six_axis_pid_thruster_mixer_top import sapm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_roll_deg,
    input  logic signed [15:0] i_pitch_deg,
    input  logic signed [15:0] i_yaw_deg,
    input  logic signed [15:0] i_depth_meas,
    input  logic signed [15:0] i_target_0,
    input  logic signed [15:0] i_target_1,
    input  logic signed [15:0] i_target_2,
    input  logic signed [15:0] i_target_3,
    input  logic signed [15:0] i_target_4,
    input  logic signed [15:0] i_target_5,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [10:0]        o_thrust_0,
    output logic [10:0]        o_thrust_1,
    output logic [10:0]        o_thrust_2,
    output logic [10:0]        o_thrust_3,
    output logic [10:0]        o_thrust_4,
    output logic [10:0]        o_thrust_5,
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_idx,
    input  logic [59:0]        i_cfg_data
);

    t_cmd               w_cmd;
    t_stat              w_stat;
    logic signed [15:0] w_deg [3];
    logic signed [15:0] w_tgt [6];
    logic [10:0]        w_thrust [6];

    assign w_deg[0] = i_roll_deg;
    assign w_deg[1] = i_pitch_deg;
    assign w_deg[2] = i_yaw_deg;
    assign w_tgt[0] = i_target_0;
    assign w_tgt[1] = i_target_1;
    assign w_tgt[2] = i_target_2;
    assign w_tgt[3] = i_target_3;
    assign w_tgt[4] = i_target_4;
    assign w_tgt[5] = i_target_5;

    sapm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    sapm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_deg       (w_deg),
        .i_depth     (i_depth_meas),
        .i_tgt       (w_tgt),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_thrust    (w_thrust)
    );

    assign o_thrust_0 = w_thrust[0];
    assign o_thrust_1 = w_thrust[1];
    assign o_thrust_2 = w_thrust[2];
    assign o_thrust_3 = w_thrust[3];
    assign o_thrust_4 = w_thrust[4];
    assign o_thrust_5 = w_thrust[5];

endmodule
